[design/arq_pkg.sv]
// Shared types and constants for the retransmission tracker.
// Holds field widths, action and result codes, controller states and the
// command and status structs between the controller and the datapath.
package arq_pkg;

	localparam int ACT_W      = 2;
	localparam int TAG_W      = 16;
	localparam int FLAG_W     = 8;
	localparam int SEQ_W      = 32;
	localparam int RXLEN_W    = 12;
	localparam int KIND_W     = 3;
	localparam int LEN_W      = 11;
	localparam int TIME_W     = 32;
	localparam int TMO_W      = 8;
	localparam int LCALC_W    = 16;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_PAD_W  = OUT_DATA_W - SEQ_W - TAG_W - LEN_W;

	localparam int TMO_RESET        = 2;
	localparam int MAX_PACKET_BYTES = 2048;
	localparam int HEADER_BYTES     = 5;
	localparam int FLAG_ACK_BIT     = 0;

	typedef enum logic [ACT_W-1:0] {
		ACT_SEND = 2'd0,
		ACT_TICK = 2'd1,
		ACT_RX   = 2'd2
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT   = 3'd0,
		KIND_REFUSE   = 3'd1,
		KIND_RETX     = 3'd2,
		KIND_ACKREPLY = 3'd3,
		KIND_DELIVER  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SRC_SEND     = 2'd0,
		SRC_ACKREPLY = 2'd1,
		SRC_DELIVER  = 2'd2,
		SRC_PEND     = 2'd3
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEND_SCAN,
		ST_SEND_EMIT,
		ST_ACK_SCAN,
		ST_RX_REPLY,
		ST_RX_DELIVER,
		ST_TICK_SCAN,
		ST_TICK_EVAL,
		ST_TICK_DUE,
		ST_TICK_FLUSH
	} state_t;

	typedef struct packed {
		logic item_load;
		logic scan_start;
		logic scan_run;
		logic time_inc;
		logic table_write;
		logic valid_clear;
		logic pass_advance;
		logic pend_capture;
		logic pend_clear;
		logic stamp_write;
		logic out_load;
		src_t out_src;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             ack;
		logic             slot_free;
		logic             idx_last;
		logic             s1_vld;
		logic             s1_last;
		logic             ack_hit;
		logic             best_found;
		logic             best_due;
		logic             pend_valid;
		logic             out_free;
	} st_t;

endpackage

[design/arq_ctrl.sv]
// Controller state machine of the retransmission tracker.
// Depends on arq_pkg; drives datapath commands from datapath status.
module arq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  arq_pkg::st_t  st,
	output arq_pkg::cmd_t cmd
);
	import arq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.item_load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.scan_start = 1'b1;
				unique case (st.action)
					ACT_SEND: state_d = ST_SEND_SCAN;
					ACT_TICK: begin
						cmd.time_inc = 1'b1;
						state_d = ST_TICK_SCAN;
					end
					ACT_RX:   state_d = st.ack ? ST_ACK_SCAN : ST_RX_REPLY;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_SEND_SCAN: begin
				if (st.slot_free || st.idx_last) begin
					state_d = ST_SEND_EMIT;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ST_SEND_EMIT: begin
				if (st.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_src     = SRC_SEND;
					cmd.out_last    = 1'b1;
					cmd.table_write = st.slot_free;
					state_d = ST_IDLE;
				end
			end
			ST_ACK_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.ack_hit) begin
					cmd.valid_clear = 1'b1;
					state_d = ST_IDLE;
				end else if (st.s1_vld && st.s1_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RX_REPLY: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_ACKREPLY;
					state_d = ST_RX_DELIVER;
				end
			end
			ST_RX_DELIVER: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_src  = SRC_DELIVER;
					cmd.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK_SCAN: begin
				cmd.scan_run = 1'b1;
				if (st.s1_vld && st.s1_last) begin
					state_d = ST_TICK_EVAL;
				end
			end
			ST_TICK_EVAL: begin
				priority if (!st.best_found) begin
					state_d = ST_TICK_FLUSH;
				end else if (st.best_due) begin
					state_d = ST_TICK_DUE;
				end else begin
					cmd.pass_advance = 1'b1;
					state_d = ST_TICK_SCAN;
				end
			end
			ST_TICK_DUE: begin
				if (!st.pend_valid || st.out_free) begin
					cmd.out_load     = st.pend_valid;
					cmd.out_src      = SRC_PEND;
					cmd.pend_capture = 1'b1;
					cmd.stamp_write  = 1'b1;
					cmd.pass_advance = 1'b1;
					state_d = ST_TICK_SCAN;
				end
			end
			ST_TICK_FLUSH: begin
				priority if (!st.pend_valid) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = SRC_PEND;
					cmd.out_last   = 1'b1;
					cmd.pend_clear = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[design/arq_dpath.sv]
// Datapath of the retransmission tracker: slot memories, valid bits,
// scan pipeline, oldest-first selection, timers and the output register.
// Depends on arq_pkg; commanded by arq_ctrl.
module arq_dpath #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [arq_pkg::TMO_W-1:0]       cfg_data,
	input  logic [arq_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [arq_pkg::ACT_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [arq_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [arq_pkg::KIND_W-1:0]      m_tuser,
	output logic                            m_tlast,
	input  arq_pkg::cmd_t                   cmd,
	output arq_pkg::st_t                    st
);
	import arq_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

	logic [ACT_W-1:0]   act_q;
	logic [TAG_W-1:0]   tag_in_q;
	logic [FLAG_W-1:0]  flags_q;
	logic [SEQ_W-1:0]   rxseq_q;
	logic [RXLEN_W-1:0] rxlen_q;

	logic [TMO_W-1:0]   timeout_q;
	logic [SEQ_W-1:0]   next_seq_q;
	logic [TIME_W-1:0]  time_now_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	logic [SEQ_W-1:0]  seq_mem   [TABLE_SLOTS];
	logic [TIME_W-1:0] stamp_mem [TABLE_SLOTS];
	logic [TAG_W-1:0]  tag_mem   [TABLE_SLOTS];

	logic [IW-1:0]     idx_q;
	logic              issued_all_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [SEQ_W-1:0]  rd_seq_s1;
	logic [TIME_W-1:0] rd_stamp_s1;
	logic [TAG_W-1:0]  rd_tag_s1;

	logic              prev_valid_q;
	logic [SEQ_W-1:0]  prev_age_q;
	logic [IW-1:0]     prev_idx_q;
	logic              best_found_q;
	logic [SEQ_W-1:0]  best_age_q;
	logic [IW-1:0]     best_idx_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [TIME_W-1:0] best_stamp_q;
	logic [TAG_W-1:0]  best_tag_q;

	logic              pend_valid_q;
	logic [SEQ_W-1:0]  pend_seq_q;
	logic [TAG_W-1:0]  pend_tag_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	logic              rd_en;
	logic              stamp_we;
	logic [IW-1:0]     stamp_addr;
	logic [SEQ_W-1:0]  age_c;
	logic              cand;
	logic              take;
	logic              slot_free;
	logic              out_free;
	logic [LCALC_W-1:0] len_ext;
	logic [LCALC_W-1:0] len_cap;
	logic [LCALC_W-1:0] len_pay;
	kind_t             ld_kind;
	logic [SEQ_W-1:0]  ld_seq;
	logic [TAG_W-1:0]  ld_tag;
	logic [LEN_W-1:0]  ld_len;

	assign rd_en      = cmd.scan_run && !issued_all_q;
	assign stamp_we   = cmd.table_write || cmd.stamp_write;
	assign stamp_addr = cmd.table_write ? idx_q : best_idx_q;
	assign slot_free  = !valid_q[idx_q];
	assign out_free   = !out_valid_q || m_tready;

	// Age grows with every send; ties between equal ages go to the lower slot.
	assign age_c = next_seq_q - rd_seq_s1;
	assign cand  = valid_q[idx_s1] && (!prev_valid_q || (age_c < prev_age_q) ||
		((age_c == prev_age_q) && (idx_s1 > prev_idx_q)));
	assign take  = cand && (!best_found_q || (age_c > best_age_q));

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			act_q    <= s_tuser;
			tag_in_q <= s_tdata[15:0];
			flags_q  <= s_tdata[23:16];
			rxseq_q  <= s_tdata[55:24];
			rxlen_q  <= s_tdata[67:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TMO_W'(TMO_RESET);
			next_seq_q <= '0;
			time_now_q <= '0;
			valid_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (cmd.time_inc) begin
				time_now_q <= time_now_q + 1'b1;
			end
			if (cmd.table_write) begin
				next_seq_q     <= next_seq_q + 1'b1;
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.valid_clear) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.table_write) begin
			seq_mem[idx_q] <= next_seq_q;
			tag_mem[idx_q] <= tag_in_q;
		end
		if (stamp_we) begin
			stamp_mem[stamp_addr] <= time_now_q;
		end
		if (rd_en) begin
			rd_seq_s1   <= seq_mem[idx_q];
			rd_stamp_s1 <= stamp_mem[idx_q];
			rd_tag_s1   <= tag_mem[idx_q];
			idx_s1      <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
			best_found_q <= 1'b0;
			prev_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start || cmd.pass_advance) begin
				idx_q        <= '0;
				issued_all_q <= 1'b0;
				vld_s1       <= 1'b0;
				best_found_q <= 1'b0;
			end else begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					if (idx_q == LAST_IDX) begin
						issued_all_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (vld_s1 && take) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.scan_start) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.pass_advance) begin
				prev_valid_q <= 1'b1;
			end
			if (cmd.scan_start || cmd.pend_clear) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_capture) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && take) begin
			best_age_q   <= age_c;
			best_idx_q   <= idx_s1;
			best_seq_q   <= rd_seq_s1;
			best_stamp_q <= rd_stamp_s1;
			best_tag_q   <= rd_tag_s1;
		end
		if (cmd.pass_advance) begin
			prev_age_q <= best_age_q;
			prev_idx_q <= best_idx_q;
		end
		if (cmd.pend_capture) begin
			pend_seq_q <= best_seq_q;
			pend_tag_q <= best_tag_q;
		end
	end

	always_comb begin
		len_ext = LCALC_W'(rxlen_q);
		len_cap = (len_ext > LCALC_W'(MAX_PACKET_BYTES)) ? LCALC_W'(MAX_PACKET_BYTES) : len_ext;
		len_pay = (len_cap > LCALC_W'(HEADER_BYTES)) ? (len_cap - LCALC_W'(HEADER_BYTES)) : '0;
	end

	always_comb begin
		ld_kind = KIND_RETX;
		ld_seq  = pend_seq_q;
		ld_tag  = pend_tag_q;
		ld_len  = '0;
		unique case (cmd.out_src)
			SRC_SEND: begin
				ld_kind = slot_free ? KIND_ACCEPT : KIND_REFUSE;
				ld_seq  = slot_free ? next_seq_q : '0;
				ld_tag  = tag_in_q;
			end
			SRC_ACKREPLY: begin
				ld_kind = KIND_ACKREPLY;
				ld_seq  = rxseq_q;
				ld_tag  = '0;
			end
			SRC_DELIVER: begin
				ld_kind = KIND_DELIVER;
				ld_seq  = rxseq_q;
				ld_tag  = '0;
				ld_len  = len_pay[LEN_W-1:0];
			end
			SRC_PEND: begin
				ld_kind = KIND_RETX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind_q <= ld_kind;
			out_seq_q  <= ld_seq;
			out_tag_q  <= ld_tag;
			out_len_q  <= ld_len;
			out_last_q <= cmd.out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_len_q, out_tag_q, out_seq_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		st            = '0;
		st.action     = act_q;
		st.ack        = flags_q[FLAG_ACK_BIT];
		st.slot_free  = slot_free;
		st.idx_last   = (idx_q == LAST_IDX);
		st.s1_vld     = vld_s1;
		st.s1_last    = (idx_s1 == LAST_IDX);
		st.ack_hit    = vld_s1 && valid_q[idx_s1] && (rd_seq_s1 == rxseq_q);
		st.best_found = best_found_q;
		st.best_due   = (time_now_q - best_stamp_q) > {{(TIME_W - TMO_W){1'b0}}, timeout_q};
		st.pend_valid = pend_valid_q;
		st.out_free   = out_free;
	end

endmodule

[design/arq_retransmit_tracker_core.sv]
// Top level of the retransmission tracker for a reliable datagram link.
// Depends on arq_pkg, arq_ctrl and arq_dpath.
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: send_tag, rx_flags, rx_seq, rx_length
// m_*      out  m_tvalid/m_tready  tuser: kind; tdata: seq, tag, payload_length; tlast: last
// cfg_*    in   cfg_we             cfg_data: retransmit_timeout
//
// One item at a time is taken; slots are read one per cycle.
// Send scans for a free slot; acknowledge scans to its match or the last slot; a data
// packet gives a reply, then a delivery; a tick makes a pass per valid slot, oldest first.
// Reset clears the valid bits at once; there is no clearing pass.
// A stalled output holds the word in place and delays the results after it.
module arq_retransmit_tracker_core #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [arq_pkg::TMO_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0: send_tag[15:0], rx_flags[23:16], rx_seq[55:24], rx_length[67:56], zeros.
	input  logic [arq_pkg::IN_DATA_W-1:0]   s_tdata,
	// From bit 0: action[1:0].
	input  logic [arq_pkg::ACT_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0: seq[31:0], tag[47:32], payload_length[58:48], zeros.
	output logic [arq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// From bit 0: kind[2:0].
	output logic [arq_pkg::KIND_W-1:0]      m_tuser,
	output logic                            m_tlast
);
	import arq_pkg::*;

	cmd_t cmd;
	st_t  st;

	arq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	arq_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

[design/arq_checker.sv]
// Port-level checks for the retransmission tracker, bound to the top level.
// Depends on arq_pkg for the result kind codes and the field widths.
module arq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [arq_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [arq_pkg::KIND_W-1:0]      m_tuser,
	input logic                            m_tlast
);
	import arq_pkg::*;

	logic              out_acc;
	logic              reply_pend_q;
	logic [SEQ_W-1:0]  reply_seq_q;

	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_pend_q <= 1'b0;
		end else if (out_acc) begin
			reply_pend_q <= (m_tuser == KIND_ACKREPLY);
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			reply_seq_q <= m_tdata[31:0];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output word changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (m_tuser != KIND_RETX) |-> (m_tlast == (m_tuser != KIND_ACKREPLY)))
		else $error("last flag does not match the result kind");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && reply_pend_q |-> (m_tuser == KIND_DELIVER) && (m_tdata[31:0] == reply_seq_q))
		else $error("acknowledge reply not followed by its delivery");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> ((m_tuser == KIND_DELIVER) || (m_tdata[58:48] == '0)) &&
		((m_tuser != KIND_REFUSE) || (m_tdata[31:0] == '0)))
		else $error("unused result field is not zero");

endmodule

bind arq_retransmit_tracker_core arq_checker u_arq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/arq_retransmit_tracker_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the retransmission tracker core.
// Depends on arq_pkg and arq_retransmit_tracker_core. It runs named tests in turn,
// predicts every result word in-line and checks each output word as it is accepted.
module arq_retransmit_tracker_core_test;
	import arq_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int QUIET_CYCLES = (SLOTS + 1) * (SLOTS + 2) + SLOTS + 32;
	localparam int DRAIN_LIMIT = 40000;
	localparam int MAX_REPORTS = 40;
	localparam int PHASE_WORDS = 90;
	localparam int STALL_CYCLES = 400;
	localparam logic [ACT_W-1:0] ACT_UNDEFINED = 2'd3;
	localparam logic [FLAG_W-1:0] ACK_FLAG = 8'h01;

	typedef struct {
		kind_t            kind;
		logic [SEQ_W-1:0] seq;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] plen;
		logic             last;
	} result_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TMO_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [ACT_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	logic [TMO_W-1:0]  tmo_ticks = TMO_W'(TMO_RESET);
	logic [SEQ_W-1:0]  next_seq_no = '0;
	logic [TIME_W-1:0] clock_secs = '0;
	logic              slot_busy [SLOTS];
	logic [SEQ_W-1:0]  slot_seq_no [SLOTS];
	logic [TIME_W-1:0] slot_sent_at [SLOTS];
	logic [TAG_W-1:0]  slot_tag_id [SLOTS];
	result_word_t      awaited_words [$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_stall_cycles = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int retx_seen = 0;
	int refuse_seen = 0;
	int settings_used = 0;

	arq_retransmit_tracker_core #(
		.TABLE_SLOTS(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words still awaited.",
				cycle_count, awaited_words.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] word %0d: %s", $time, words_out, what);
		mismatches++;
	endtask

	function automatic result_word_t make_word(kind_t k, logic [SEQ_W-1:0] sq,
		logic [TAG_W-1:0] tg, logic [LEN_W-1:0] pl);
		result_word_t w;
		w.kind = k;
		w.seq = sq;
		w.tag = tg;
		w.plen = pl;
		w.last = 1'b0;
		return w;
	endfunction

	function automatic logic [SEQ_W-1:0] slot_age(int s);
		return next_seq_no - slot_seq_no[s];
	endfunction

	// Updates the table copy for one accepted word and queues the words it should produce.
	task automatic track_word(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
		logic [FLAG_W-1:0] flags, logic [SEQ_W-1:0] rseq, logic [RXLEN_W-1:0] rlen);
		result_word_t      burst [$];
		int                pick;
		bit                taken [SLOTS];
		logic [TIME_W-1:0] waited;
		logic [RXLEN_W-1:0] clipped;
		case (act)
			ACT_SEND: begin
				pick = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!slot_busy[i])
						pick = i;
				if (pick < 0) begin
					burst.push_back(make_word(KIND_REFUSE, '0, tag, '0));
				end else begin
					slot_busy[pick] = 1'b1;
					slot_seq_no[pick] = next_seq_no;
					slot_sent_at[pick] = clock_secs;
					slot_tag_id[pick] = tag;
					burst.push_back(make_word(KIND_ACCEPT, next_seq_no, tag, '0));
					next_seq_no = next_seq_no + 1'b1;
				end
			end
			ACT_TICK: begin
				clock_secs = clock_secs + 1'b1;
				for (int i = 0; i < SLOTS; i++)
					taken[i] = 1'b0;
				for (int n = 0; n < SLOTS; n++) begin
					pick = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_busy[i] && !taken[i] &&
							(pick < 0 || slot_age(i) > slot_age(pick)))
							pick = i;
					if (pick >= 0) begin
						taken[pick] = 1'b1;
						waited = clock_secs - slot_sent_at[pick];
						if (waited > TIME_W'(tmo_ticks)) begin
							burst.push_back(make_word(KIND_RETX, slot_seq_no[pick],
								slot_tag_id[pick], '0));
							slot_sent_at[pick] = clock_secs;
						end
					end
				end
			end
			ACT_RX: begin
				if (flags[FLAG_ACK_BIT]) begin
					pick = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_busy[i] && slot_seq_no[i] == rseq &&
							(pick < 0 || slot_age(i) > slot_age(pick)))
							pick = i;
					if (pick >= 0)
						slot_busy[pick] = 1'b0;
				end else begin
					clipped = (rlen > MAX_PACKET_BYTES) ? RXLEN_W'(MAX_PACKET_BYTES) : rlen;
					burst.push_back(make_word(KIND_ACKREPLY, rseq, '0, '0));
					burst.push_back(make_word(KIND_DELIVER, rseq, '0,
						(clipped > HEADER_BYTES) ? LEN_W'(clipped - HEADER_BYTES) : '0));
				end
			end
			default: ;
		endcase
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			awaited_words.push_back(burst[i]);
	endtask

	// Offers one word; s_tvalid stays high into the next word when no gap is drawn.
	task automatic offer_word(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
		logic [FLAG_W-1:0] flags, logic [SEQ_W-1:0] rseq, logic [RXLEN_W-1:0] rlen);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= IN_DATA_W'({rlen, rseq, flags, tag});
		do @(posedge clk); while (!s_tready);
		words_in++;
		track_word(act, tag, flags, rseq, rlen);
	endtask

	task automatic offer_random_word();
		int                 roll;
		int                 busy_slots [$];
		logic [SEQ_W-1:0]   rseq;
		logic [RXLEN_W-1:0] rlen;
		logic [FLAG_W-1:0]  flags;
		roll = $urandom_range(0, 99);
		rseq = SEQ_W'($urandom);
		flags = FLAG_W'($urandom);
		case ($urandom_range(0, 9))
			0: rlen = RXLEN_W'($urandom_range(0, 6));
			1, 2, 3: rlen = RXLEN_W'($urandom_range(7, 64));
			4, 5, 6, 7: rlen = RXLEN_W'($urandom_range(65, MAX_PACKET_BYTES));
			default: rlen = RXLEN_W'($urandom_range(MAX_PACKET_BYTES - 1, 4095));
		endcase
		if (roll < 30) begin
			offer_word(ACT_SEND, TAG_W'($urandom), flags, rseq, rlen);
		end else if (roll < 50) begin
			offer_word(ACT_TICK, TAG_W'($urandom), flags, rseq, rlen);
		end else if (roll < 78) begin
			for (int i = 0; i < SLOTS; i++)
				if (slot_busy[i])
					busy_slots.push_back(i);
			if (busy_slots.size() > 0)
				rseq = slot_seq_no[busy_slots[$urandom_range(0, busy_slots.size() - 1)]];
			offer_word(ACT_RX, TAG_W'($urandom), flags | ACK_FLAG, rseq, rlen);
		end else if (roll < 95) begin
			offer_word(ACT_RX, TAG_W'($urandom), flags & ~ACK_FLAG, rseq, rlen);
		end else if (roll < 97) begin
			offer_word(ACT_RX, TAG_W'($urandom), flags | ACK_FLAG,
				next_seq_no - SEQ_W'($urandom_range(1, 24)), rlen);
		end else if (roll < 98) begin
			offer_word(ACT_RX, TAG_W'($urandom), flags | ACK_FLAG, rseq, rlen);
		end else begin
			offer_word(ACT_UNDEFINED, TAG_W'($urandom), flags, rseq, rlen);
		end
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		while (awaited_words.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_words.size() > 0) begin
			report_mismatch($sformatf("%0d expected words never arrived",
				awaited_words.size()));
			awaited_words.delete();
		end
	endtask

	// Acknowledges give no word, so a scan may still run after the last word is out.
	task automatic settle();
		s_tvalid <= 1'b0;
		wait_for_results();
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TMO_W-1:0] ticks);
		cfg_we <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		tmo_ticks = ticks;
		settings_used++;
	endtask

	task automatic run_random_phase(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			offer_random_word();
		end
	endtask

	task automatic test_packet_edges();
		offer_word(ACT_RX, 16'h0000, 8'h00, 32'h0000_0000, 12'd0);
		offer_word(ACT_RX, 16'hFFFF, 8'hFE, 32'hFFFF_FFFF, 12'd5);
		offer_word(ACT_RX, 16'h5A5A, 8'h80, 32'hA5A5_5A5A, 12'd6);
		offer_word(ACT_RX, 16'h0001, 8'h7E, 32'h8000_0001, 12'd2048);
		offer_word(ACT_RX, 16'h8000, 8'h02, 32'h7FFF_FFFE, 12'hFFF);
		offer_word(ACT_RX, 16'hFFFF, 8'hFF, 32'h1234_5678, 12'hFFF);
		offer_word(ACT_UNDEFINED, 16'hFFFF, 8'hFE, 32'hFFFF_FFFF, 12'hFFF);
		offer_word(ACT_TICK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 12'hFFF);
	endtask

	// Fills the table, frees a middle entry and lets every entry time out in one tick.
	task automatic test_table_full();
		offer_word(ACT_SEND, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 12'hFFF);
		offer_word(ACT_SEND, 16'hFFFF, 8'h00, 32'h0000_0000, 12'd0);
		for (int n = 0; n < SLOTS - 2; n++)
			offer_word(ACT_SEND, TAG_W'($urandom), FLAG_W'($urandom), SEQ_W'($urandom),
				RXLEN_W'($urandom));
		offer_word(ACT_SEND, 16'hBEEF, 8'h01, 32'h0000_0005, 12'd100);
		offer_word(ACT_RX, 16'h0000, ACK_FLAG, 32'd5, 12'd0);
		offer_word(ACT_SEND, 16'h1234, 8'h00, 32'd0, 12'd0);
		repeat (3)
			offer_word(ACT_TICK, TAG_W'($urandom), FLAG_W'($urandom), SEQ_W'($urandom),
				RXLEN_W'($urandom));
		offer_word(ACT_RX, 16'h0000, 8'h81, 32'd0, 12'd0);
	endtask

	task automatic test_timeout_sweep();
		logic [TMO_W-1:0] ticks [5];
		ticks[0] = 8'd0;
		ticks[1] = 8'd255;
		ticks[2] = 8'd1;
		ticks[3] = TMO_W'($urandom_range(3, 9));
		ticks[4] = TMO_W'(TMO_RESET);
		foreach (ticks[i]) begin
			settle();
			write_timeout(ticks[i]);
			run_random_phase(PHASE_WORDS);
		end
	endtask

	// The receiver holds off while words keep coming, so the core must stall its input.
	task automatic test_output_stall();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_stall_cycles = STALL_CYCLES;
		for (int n = 0; n < 30; n++)
			offer_word(ACT_RX, TAG_W'($urandom), FLAG_W'($urandom) & ~ACK_FLAG,
				SEQ_W'($urandom), RXLEN_W'($urandom));
		for (int n = 0; n < 10; n++)
			offer_random_word();
		s_tvalid <= 1'b0;
		wait_for_results();
		rx_idle_on = 1'b1;
		tx_idle_on = 1'b1;
		for (int n = 0; n < 10; n++)
			offer_random_word();
	endtask

	initial begin
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_stall_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (rx_stall_cycles) @(posedge clk);
				rx_stall_cycles = 0;
			end
			gap = rx_idle_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && rx_stall_cycles == 0);
		end
	end

	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (m_tuser == KIND_RETX)
				retx_seen++;
			if (m_tuser == KIND_REFUSE)
				refuse_seen++;
			if (awaited_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d seq %h",
					m_tuser, m_tdata[SEQ_W-1:0]));
			end else begin
				want = awaited_words.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %s", m_tuser,
						want.kind.name()));
				if (m_tdata[SEQ_W-1:0] !== want.seq)
					report_mismatch($sformatf("seq %h, expected %h", m_tdata[SEQ_W-1:0],
						want.seq));
				if (m_tdata[SEQ_W +: TAG_W] !== want.tag)
					report_mismatch($sformatf("tag %h, expected %h", m_tdata[SEQ_W +: TAG_W],
						want.tag));
				if (m_tdata[SEQ_W + TAG_W +: LEN_W] !== want.plen)
					report_mismatch($sformatf("payload length %0d, expected %0d",
						m_tdata[SEQ_W + TAG_W +: LEN_W], want.plen));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
				if (m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0)
					report_mismatch($sformatf("padding bits %h not zero",
						m_tdata[OUT_DATA_W-1 -: OUT_PAD_W]));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= '0;
		s_tdata <= '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_seq_no[i] = '0;
			slot_sent_at[i] = '0;
			slot_tag_id[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_packet_edges();
		test_table_full();
		test_timeout_sweep();
		test_output_stall();
		settle();
		$display("Covered %0d input words and %0d result words, with %0d retransmits and %0d",
			words_in, words_out, retx_seen, refuse_seen);
		$display("refused sends, across %0d timeout settings and one long output stall.",
			settings_used);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
design/arq_pkg.sv
design/arq_ctrl.sv
design/arq_dpath.sv
design/arq_retransmit_tracker_core.sv
design/arq_checker.sv
tb/arq_retransmit_tracker_core_test.sv
